>>> hdl/aarc_pkg.sv
// ----------------------------------------------------------------------------
// aarc_pkg
// Shared types and constants of the axis-aligned rectangle counter.
// ----------------------------------------------------------------------------
package aarc_pkg;

	localparam int MAX_POINTS = 256;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int FILL_W     = IDX_W + 1;
	localparam int COUNT_W    = 15;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} point_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_RD_A,
		S_LD_A,
		S_RD_B,
		S_LD_B,
		S_SCAN,
		S_DRAIN,
		S_OUT
	} state_t;

endpackage

>>> hdl/axis_aligned_rectangle_counter_core.sv
// ----------------------------------------------------------------------------
// axis_aligned_rectangle_counter_core
// Loads points, then counts axis-aligned rectangles over the stored set.
// ----------------------------------------------------------------------------
//  channel | signals                         | accepted when
//  input   | in_valid in_stall px py last    | in_valid && !in_stall
//  output  | out_valid out_stall rect_count  | out_valid && !out_stall
//          | dropped                         |
//
//  Points load one per cycle while in_stall is low. After the last point
//  the search runs with in_stall high: each pair of stored points is read,
//  and for each pair that lies strictly below-left the other two corners
//  are scanned for through the single read port of the store.
//  The result then waits in its register until taken; in_stall falls
//  after. Reset clears fill count, overflow flag and sequencer; the store
//  is not.
module axis_aligned_rectangle_counter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [15:0]                   px,
	input  logic signed [15:0]                   py,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [aarc_pkg::COUNT_W-1:0]         rect_count,
	output logic                                 dropped
);

	aarc_pkg::state_t state_q, state_d;

	logic [aarc_pkg::FILL_W-1:0]  fill_q;
	logic                         ovf_q;
	logic [aarc_pkg::IDX_W-1:0]   a_q, b_q, k_q;
	logic [aarc_pkg::IDX_W-1:0]   last_idx;
	aarc_pkg::point_t             pa_q, pb_q, rdata, wdata;
	logic                         chk_q, f1_q, f2_q;
	logic [aarc_pkg::COUNT_W-1:0] cnt_q;
	logic [aarc_pkg::IDX_W-1:0]   raddr;
	logic                         acc, we, hit1, hit2, below_left;

	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != aarc_pkg::S_LOAD);
	assign we       = acc && (fill_q < aarc_pkg::FILL_W'(aarc_pkg::MAX_POINTS));
	assign wdata.x  = px[aarc_pkg::COORD_BITS-1:0];
	assign wdata.y  = py[aarc_pkg::COORD_BITS-1:0];
	assign last_idx = aarc_pkg::IDX_W'(fill_q - aarc_pkg::FILL_W'(1));

	assign hit1       = chk_q && (rdata.x == pb_q.x) && (rdata.y == pa_q.y);
	assign hit2       = chk_q && (rdata.x == pa_q.x) && (rdata.y == pb_q.y);
	assign below_left = (pa_q.x < rdata.x) && (pa_q.y < rdata.y);

	aarc_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (fill_q[aarc_pkg::IDX_W-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		raddr   = k_q;
		case (state_q)
			aarc_pkg::S_LOAD: begin
				if (acc && last) begin
					state_d = aarc_pkg::S_RD_A;
				end
			end
			aarc_pkg::S_RD_A: begin
				raddr   = a_q;
				state_d = aarc_pkg::S_LD_A;
			end
			aarc_pkg::S_LD_A: begin
				state_d = aarc_pkg::S_RD_B;
			end
			aarc_pkg::S_RD_B: begin
				raddr   = b_q;
				state_d = aarc_pkg::S_LD_B;
			end
			aarc_pkg::S_LD_B: begin
				if (below_left) begin
					state_d = aarc_pkg::S_SCAN;
				end else if (b_q != last_idx) begin
					state_d = aarc_pkg::S_RD_B;
				end else if (a_q != last_idx) begin
					state_d = aarc_pkg::S_RD_A;
				end else begin
					state_d = aarc_pkg::S_OUT;
				end
			end
			aarc_pkg::S_SCAN: begin
				raddr = k_q;
				if (k_q == last_idx) begin
					state_d = aarc_pkg::S_DRAIN;
				end
			end
			aarc_pkg::S_DRAIN: begin
				if (b_q != last_idx) begin
					state_d = aarc_pkg::S_RD_B;
				end else if (a_q != last_idx) begin
					state_d = aarc_pkg::S_RD_A;
				end else begin
					state_d = aarc_pkg::S_OUT;
				end
			end
			aarc_pkg::S_OUT: begin
				if (!out_stall) begin
					state_d = aarc_pkg::S_LOAD;
				end
			end
			default: begin
				state_d = aarc_pkg::S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aarc_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			a_q    <= '0;
			b_q    <= '0;
			k_q    <= '0;
			chk_q  <= 1'b0;
			f1_q   <= 1'b0;
			f2_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			chk_q <= 1'b0;
			case (state_q)
				aarc_pkg::S_LOAD: begin
					if (we) begin
						fill_q <= fill_q + aarc_pkg::FILL_W'(1);
					end else if (acc) begin
						ovf_q <= 1'b1;
					end
					a_q   <= '0;
					cnt_q <= '0;
				end
				aarc_pkg::S_LD_A: begin
					b_q <= '0;
				end
				aarc_pkg::S_LD_B: begin
					k_q  <= '0;
					f1_q <= 1'b0;
					f2_q <= 1'b0;
					if (!below_left) begin
						if (b_q != last_idx) begin
							b_q <= b_q + aarc_pkg::IDX_W'(1);
						end else begin
							a_q <= a_q + aarc_pkg::IDX_W'(1);
						end
					end
				end
				aarc_pkg::S_SCAN: begin
					k_q   <= k_q + aarc_pkg::IDX_W'(1);
					chk_q <= 1'b1;
					f1_q  <= f1_q | hit1;
					f2_q  <= f2_q | hit2;
				end
				aarc_pkg::S_DRAIN: begin
					if ((f1_q || hit1) && (f2_q || hit2) && (cnt_q != aarc_pkg::COUNT_MAX)) begin
						cnt_q <= cnt_q + aarc_pkg::COUNT_W'(1);
					end
					if (b_q != last_idx) begin
						b_q <= b_q + aarc_pkg::IDX_W'(1);
					end else begin
						a_q <= a_q + aarc_pkg::IDX_W'(1);
					end
				end
				aarc_pkg::S_OUT: begin
					if (!out_stall) begin
						fill_q <= '0;
						ovf_q  <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aarc_pkg::S_LD_A) begin
			pa_q <= rdata;
		end
		if (state_q == aarc_pkg::S_LD_B) begin
			pb_q <= rdata;
		end
	end

	assign out_valid  = (state_q == aarc_pkg::S_OUT);
	assign rect_count = cnt_q;
	assign dropped    = ovf_q;

endmodule

>>> hdl/aarc_store.sv
// ----------------------------------------------------------------------------
// aarc_store
// Point store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aarc_store (
	input  logic                    clk,
	input  logic                    we,
	input  logic [aarc_pkg::IDX_W-1:0] waddr,
	input  aarc_pkg::point_t        wdata,
	input  logic [aarc_pkg::IDX_W-1:0] raddr,
	output aarc_pkg::point_t        rdata
);

	aarc_pkg::point_t mem [aarc_pkg::MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/aarc_check.sv
// ----------------------------------------------------------------------------
// aarc_check
// Port-level checks of the rectangle counter, bound to the top level.
// ----------------------------------------------------------------------------
module aarc_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         last,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [aarc_pkg::COUNT_W-1:0] rect_count,
	input logic                         dropped
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rect_count) && $stable(dropped))
		else $error("result changed while stalled");

	a_busy_on_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall)
		else $error("no search after final request");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid && !in_stall)
		else $error("block not released after result");

endmodule

bind axis_aligned_rectangle_counter_core aarc_check u_aarc_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last       (last),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.rect_count (rect_count),
	.dropped    (dropped)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Rectangle counter check: sends point sets over the request channel with
// random gaps, predicts each rectangle count in the bench, and compares
// every result field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct {
		logic [aarc_pkg::COUNT_W-1:0] count;
		logic                         dropped;
	} rect_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic signed [15:0]             px;
	logic signed [15:0]             py;
	logic                           last;
	logic                           out_valid;
	logic                           out_stall;
	logic [aarc_pkg::COUNT_W-1:0]   rect_count;
	logic                           dropped;

	logic signed [15:0] held_x [aarc_pkg::MAX_POINTS];
	logic signed [15:0] held_y [aarc_pkg::MAX_POINTS];
	int                 held_fill;
	logic               held_overflow;
	rect_result_t       pending_counts [$];

	int  errors;
	int  points_sent;
	int  sets_sent;
	int  results_seen;
	int  overflow_sets;
	bit  calm;
	int  stall_left;

	axis_aligned_rectangle_counter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.px        (px),
		.py        (py),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rect_count(rect_count),
		.dropped   (dropped)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic bit is_held(logic signed [15:0] x, logic signed [15:0] y);
		for (int k = 0; k < held_fill; k++)
			if (held_x[k] == x && held_y[k] == y)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [aarc_pkg::COUNT_W-1:0] count_rectangles();
		int n;
		n = 0;
		for (int a = 0; a < held_fill; a++)
			for (int b = 0; b < held_fill; b++)
				if (held_x[a] < held_x[b] && held_y[a] < held_y[b] &&
				    is_held(held_x[b], held_y[a]) && is_held(held_x[a], held_y[b]))
					if (n < int'(aarc_pkg::COUNT_MAX))
						n++;
		return aarc_pkg::COUNT_W'(n);
	endfunction

	function automatic void predict_point(logic signed [15:0] x, logic signed [15:0] y,
	                                      logic l);
		rect_result_t r;
		if (held_fill < aarc_pkg::MAX_POINTS) begin
			held_x[held_fill] = x;
			held_y[held_fill] = y;
			held_fill++;
		end else begin
			held_overflow = 1'b1;
		end
		if (l) begin
			r.count   = count_rectangles();
			r.dropped = held_overflow;
			if (held_overflow)
				overflow_sets++;
			pending_counts = {pending_counts, r};
			held_fill     = 0;
			held_overflow = 1'b0;
			sets_sent++;
		end
	endfunction

	task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic l);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		px       <= x;
		py       <= y;
		last     <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_point(x, y, l);
		points_sent++;
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// ---- output side: stall bursts, checking ----
	always @(negedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_stall <= 1'b0;
			end else begin
				out_stall  <= 1'b1;
				stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			rect_result_t e;
			results_seen++;
			if (pending_counts.size() == 0) begin
				$display("%0t: result with nothing expected: rect_count %0d dropped %0b",
				         $time, rect_count, dropped);
				errors++;
			end else begin
				e = pending_counts.pop_front();
				if (rect_count !== e.count) begin
					$display("%0t: rect_count expected %0d actual %0d",
					         $time, e.count, rect_count);
					errors++;
				end
				if (dropped !== e.dropped) begin
					$display("%0t: dropped expected %0b actual %0b",
					         $time, e.dropped, dropped);
					errors++;
				end
			end
		end
	end

	// ---- tests ----
	task automatic test_extreme_rectangle();
		send_point(-16'sd32768, -16'sd32768, 1'b0);
		send_point( 16'sd32767, -16'sd32768, 1'b0);
		send_point(-16'sd32768,  16'sd32767, 1'b0);
		send_point( 16'sd32767,  16'sd32767, 1'b1);
		send_point(16'sh5555, 16'shAAAA, 1'b0);
		send_point(16'shAAAA, 16'sh5555, 1'b0);
		send_point(16'sh5555, 16'sh5555, 1'b0);
		send_point(16'shAAAA, 16'shAAAA, 1'b1);
	endtask

	task automatic test_too_few();
		send_point(16'sd0, 16'sd0, 1'b1);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd3, 16'sd3, 1'b1);
		send_point(-16'sd1, -16'sd1, 1'b0);
		send_point(16'sd1, -16'sd1, 1'b0);
		send_point(-16'sd1, 16'sd1, 1'b1);
	endtask

	task automatic test_repeats();
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd4, 16'sd0, 1'b0);
		send_point(16'sd0, 16'sd4, 1'b0);
		send_point(16'sd4, 16'sd4, 1'b0);
		send_point(16'sd4, 16'sd4, 1'b0);
		send_point(16'sd8, 16'sd0, 1'b0);
		send_point(16'sd8, 16'sd4, 1'b1);
	endtask

	// fill past capacity; filler points sit on one row so the search stays short
	task automatic test_overflow(bit drop_final);
		int n;
		n = drop_final ? aarc_pkg::MAX_POINTS + 1 : aarc_pkg::MAX_POINTS + 3;
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd1, 16'sd0, 1'b0);
		send_point(16'sd0, 16'sd1, 1'b0);
		for (int i = 3; i < n - 1; i++)
			send_point(16'(100 + i), -16'sd5, 1'b0);
		send_point(16'sd1, 16'sd1, 1'b1);
	endtask

	task automatic test_full_no_overflow();
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd1, 16'sd0, 1'b0);
		send_point(16'sd0, 16'sd1, 1'b0);
		for (int i = 3; i < aarc_pkg::MAX_POINTS - 1; i++)
			send_point(16'(100 + i), -16'sd5, 1'b0);
		send_point(16'sd1, 16'sd1, 1'b1);
	endtask

	task automatic test_random_sets(int budget);
		logic signed [15:0] xs [6];
		logic signed [15:0] ys [6];
		int nx, ny, n;
		while (points_sent < budget) begin
			calm = ($urandom_range(0, 9) == 0);
			nx = $urandom_range(2, 5);
			ny = $urandom_range(2, 5);
			for (int i = 0; i < 6; i++) begin
				xs[i] = 16'($urandom());
				ys[i] = 16'($urandom());
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) < 2)
					send_point(16'($urandom()), 16'($urandom()), i == n - 1);
				else
					send_point(xs[$urandom_range(0, nx - 1)], ys[$urandom_range(0, ny - 1)],
					           i == n - 1);
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		px         = '0;
		py         = '0;
		last       = 1'b0;
		out_stall  = 1'b0;
		errors     = 0;
		points_sent = 0;
		sets_sent  = 0;
		results_seen = 0;
		overflow_sets = 0;
		held_fill  = 0;
		held_overflow = 1'b0;
		calm       = 1'b0;
		stall_left = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extreme_rectangle();
		test_too_few();
		test_repeats();
		test_overflow(1'b1);
		test_random_sets(points_sent + 100);
		test_full_no_overflow();
		test_overflow(1'b0);
		test_random_sets(points_sent + 200);
		go_idle();

		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d points in %0d sets, %0d with overflow; %0d results checked.",
		         points_sent, sets_sent, overflow_sets, results_seen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(64'd200_000_000);
		$display("Timed out with %0d results still pending.", pending_counts.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
